/* sv/i2r_pkg.sv */
package i2r_pkg;

  // Number of weights in the greedy table, M down to I.
  localparam int NumDigits = 13;
  localparam int DigitIdxW = $clog2(NumDigits);

  // Remaining value width: valid inputs are 1 to 3999.
  localparam int ValueW    = 12;
  localparam int InW       = 16;
  localparam int SymW      = 7;

  // Accepted input range.
  localparam logic signed [InW-1:0] MinValue = 16'sd1;
  localparam logic signed [InW-1:0] MaxValue = 16'sd3999;

  // The out-of-range run spells ERROR.
  localparam int ErrLen  = 5;
  localparam int ErrIdxW = $clog2(ErrLen);
  localparam logic [ErrIdxW-1:0] ErrLastIdx = ErrIdxW'(ErrLen - 1);

  // ASCII codes used by the numerals and the error text.
  localparam logic [SymW-1:0] ChM = 7'h4D;
  localparam logic [SymW-1:0] ChD = 7'h44;
  localparam logic [SymW-1:0] ChC = 7'h43;
  localparam logic [SymW-1:0] ChL = 7'h4C;
  localparam logic [SymW-1:0] ChX = 7'h58;
  localparam logic [SymW-1:0] ChV = 7'h56;
  localparam logic [SymW-1:0] ChI = 7'h49;
  localparam logic [SymW-1:0] ChE = 7'h45;
  localparam logic [SymW-1:0] ChR = 7'h52;
  localparam logic [SymW-1:0] ChO = 7'h4F;

  // Controller state, one-hot.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } status_t;

  // Weight of each table entry.
  function automatic logic [ValueW-1:0] digit_weight(input logic [DigitIdxW-1:0] idx);
    logic [ValueW-1:0] w;
    case (idx)
      4'd0:    w = 12'd1000;
      4'd1:    w = 12'd900;
      4'd2:    w = 12'd500;
      4'd3:    w = 12'd400;
      4'd4:    w = 12'd100;
      4'd5:    w = 12'd90;
      4'd6:    w = 12'd50;
      4'd7:    w = 12'd40;
      4'd8:    w = 12'd10;
      4'd9:    w = 12'd9;
      4'd10:   w = 12'd5;
      4'd11:   w = 12'd4;
      default: w = 12'd1;
    endcase
    return w;
  endfunction

  // True for the subtractive pairs such as CM or IV.
  function automatic logic digit_has_two(input logic [DigitIdxW-1:0] idx);
    logic two;
    case (idx)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11: two = 1'b1;
      default:                             two = 1'b0;
    endcase
    return two;
  endfunction

  // First character of each table entry.
  function automatic logic [SymW-1:0] digit_first(input logic [DigitIdxW-1:0] idx);
    logic [SymW-1:0] c;
    case (idx)
      4'd0, 4'd1:  c = ChM;
      4'd2:        c = ChD;
      4'd3, 4'd4:  c = ChC;
      4'd5:        c = ChX;
      4'd6:        c = ChL;
      4'd7, 4'd8:  c = ChX;
      4'd9:        c = ChI;
      4'd10:       c = ChV;
      default:     c = ChI;
    endcase
    // CM and CD start with C, XC and XL with X.
    if (idx == 4'd1) c = ChC;
    if (idx == 4'd5) c = ChX;
    return c;
  endfunction

  // Second character of the subtractive pairs.
  function automatic logic [SymW-1:0] digit_second(input logic [DigitIdxW-1:0] idx);
    logic [SymW-1:0] c;
    case (idx)
      4'd1:    c = ChM;
      4'd3:    c = ChD;
      4'd5:    c = ChC;
      4'd7:    c = ChL;
      4'd9:    c = ChX;
      4'd11:   c = ChV;
      default: c = ChI;
    endcase
    return c;
  endfunction

  // Characters of the error text.
  function automatic logic [SymW-1:0] err_char(input logic [ErrIdxW-1:0] idx);
    logic [SymW-1:0] c;
    case (idx)
      3'd0:    c = ChE;
      3'd3:    c = ChO;
      default: c = ChR;
    endcase
    return c;
  endfunction

endpackage

/* sv/integer_to_roman_numeral.sv */
// The first character appears in the cycle after the transaction is accepted.
// One character per cycle follows: up to 15 for a numeral, 5 for ERROR.
// A new transaction is accepted only in idle, so a run (at most 15 characters) must
// finish its one-character-per-cycle emit loop and return to idle first.
// Reset: asynchronous, active low; returns the controller to idle. The receiver
// cannot stall, so every character is presented for exactly one cycle.
module integer_to_roman_numeral (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [i2r_pkg::InW-1:0]  value_i,
  output logic                            strobe_o,
  output logic [i2r_pkg::SymW-1:0]        symbol_o,
  output logic                            is_error_o,
  output logic                            last_o
);

  i2r_pkg::cmd_t    cmd;
  i2r_pkg::status_t status;
  logic             strobe;

  // Sequencer.
  i2r_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .strobe_o (strobe)
  );

  // Remaining value, digit selection and character lookup.
  i2r_dp u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .value_i    (value_i),
    .status_o   (status),
    .symbol_o   (symbol_o),
    .is_error_o (is_error_o)
  );

  assign strobe_o = strobe;
  assign last_o   = strobe & status.last;

  // The final character of a run returns the block to idle.
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |=> !busy)
    else $error("busy still high after the last character");

  // A run without its last character keeps emitting.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o)
    else $error("run stopped before its last character");

  // The error flag is the same on every character of a run.
  a_err_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && $past(strobe_o) && !$past(last_o) |-> is_error_o == $past(is_error_o))
    else $error("error flag changed within a run");

  // An accepted transaction starts emitting in the next cycle.
  a_start_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> strobe_o)
    else $error("no character after an accepted transaction");

endmodule

/* sv/i2r_dp.sv */
module i2r_dp (
  input  logic                             clk_i,
  input  i2r_pkg::cmd_t                    cmd_i,
  input  logic signed [i2r_pkg::InW-1:0]   value_i,
  output i2r_pkg::status_t                 status_o,
  output logic [i2r_pkg::SymW-1:0]         symbol_o,
  output logic                             is_error_o
);

  logic [i2r_pkg::ValueW-1:0]    n_q, n_d;
  logic                          second_q, second_d;
  logic                          err_q, err_d;
  logic [i2r_pkg::ErrIdxW-1:0]   eidx_q, eidx_d;

  logic [i2r_pkg::DigitIdxW-1:0] sel;
  logic [i2r_pkg::ValueW-1:0]    rem;
  logic                          two;
  logic                          final_char;
  logic                          out_of_range;

  // Largest weight that still fits the remaining value.
  always_comb begin
    sel = i2r_pkg::DigitIdxW'(i2r_pkg::NumDigits - 1);
    for (int i = i2r_pkg::NumDigits - 1; i >= 0; i--) begin
      if (n_q >= i2r_pkg::digit_weight(i2r_pkg::DigitIdxW'(i))) begin
        sel = i2r_pkg::DigitIdxW'(i);
      end
    end
  end

  assign two        = i2r_pkg::digit_has_two(sel);
  assign final_char = !two || second_q;
  assign rem        = n_q - i2r_pkg::digit_weight(sel);

  assign out_of_range = (value_i < i2r_pkg::MinValue) || (value_i > i2r_pkg::MaxValue);

  // Character on the output this cycle.
  always_comb begin
    if (err_q) begin
      symbol_o = i2r_pkg::err_char(eidx_q);
    end else if (second_q) begin
      symbol_o = i2r_pkg::digit_second(sel);
    end else begin
      symbol_o = i2r_pkg::digit_first(sel);
    end
  end

  assign is_error_o    = err_q;
  assign status_o.last = err_q ? (eidx_q == i2r_pkg::ErrLastIdx)
                               : (final_char && (rem == '0));

  // Next-state logic for the working registers.
  always_comb begin
    n_d      = n_q;
    second_d = second_q;
    err_d    = err_q;
    eidx_d   = eidx_q;
    if (cmd_i.load) begin
      n_d      = value_i[i2r_pkg::ValueW-1:0];
      second_d = 1'b0;
      err_d    = out_of_range;
      eidx_d   = '0;
    end else if (cmd_i.step) begin
      if (err_q) begin
        eidx_d = eidx_q + 1'b1;
      end else if (final_char) begin
        n_d      = rem;
        second_d = 1'b0;
      end else begin
        second_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    second_q <= second_d;
    err_q    <= err_d;
    eidx_q   <= eidx_d;
  end

endmodule

/* sv/i2r_ctrl.sv */
module i2r_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  i2r_pkg::status_t status_i,
  output i2r_pkg::cmd_t    cmd_o,
  output logic             busy,
  output logic             strobe_o
);

  i2r_pkg::state_e state_q, state_d;

  // Load on an accepted transaction, then step once per character.
  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.step = 1'b0;
    case (state_q)
      i2r_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = i2r_pkg::S_EMIT;
        end
      end
      i2r_pkg::S_EMIT: begin
        cmd_o.step = 1'b1;
        if (status_i.last) begin
          state_d = i2r_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = i2r_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2r_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy     = (state_q != i2r_pkg::S_IDLE);
  assign strobe_o = (state_q == i2r_pkg::S_EMIT);

endmodule

/* tb/tb.sv */
module tb;

  localparam int InW  = i2r_pkg::InW;
  localparam int SymW = i2r_pkg::SymW;

  // One character of a numeral run as it should appear on the result ports.
  typedef struct {
    logic [SymW-1:0] symbol;
    logic            is_error;
    logic            last;
  } glyph_t;

  localparam int NumeralBound = 4000;
  localparam int CycleLimit   = 200000;
  localparam int ReportLimit  = 10;
  localparam int DrainCycles  = 20;

  // Greedy table: weight, first character and the second character of the
  // subtractive pairs. NoChar marks a single-character entry.
  localparam logic [SymW-1:0] NoChar = '0;
  localparam int NumeralWeight [13] = '{1000, 900, 500, 400, 100, 90, 50, 40,
                                        10, 9, 5, 4, 1};
  localparam logic [SymW-1:0] NumeralHead [13] = '{
    i2r_pkg::ChM, i2r_pkg::ChC, i2r_pkg::ChD, i2r_pkg::ChC, i2r_pkg::ChC,
    i2r_pkg::ChX, i2r_pkg::ChL, i2r_pkg::ChX, i2r_pkg::ChX, i2r_pkg::ChI,
    i2r_pkg::ChV, i2r_pkg::ChI, i2r_pkg::ChI};
  localparam logic [SymW-1:0] NumeralTail [13] = '{
    NoChar, i2r_pkg::ChM, NoChar, i2r_pkg::ChD, NoChar,
    i2r_pkg::ChC, NoChar, i2r_pkg::ChL, NoChar, i2r_pkg::ChX,
    NoChar, i2r_pkg::ChV, NoChar};
  localparam logic [SymW-1:0] ErrorText [5] = '{
    i2r_pkg::ChE, i2r_pkg::ChR, i2r_pkg::ChR, i2r_pkg::ChO, i2r_pkg::ChR};

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic signed [InW-1:0]  value_i;
  logic                   strobe_o;
  logic [SymW-1:0]        symbol_o;
  logic                   is_error_o;
  logic                   last_o;

  glyph_t pending_glyphs [$];
  int     mismatches = 0;
  int     cycles = 0;

  integer_to_roman_numeral dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .value_i    (value_i),
    .strobe_o   (strobe_o),
    .symbol_o   (symbol_o),
    .is_error_o (is_error_o),
    .last_o     (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Queue the characters that one accepted value should produce.
  function automatic void spell_numeral(input logic signed [InW-1:0] v);
    logic [SymW-1:0] chars [16];
    int              n;
    int              rest;
    logic            err;
    glyph_t          g;
    n    = 0;
    rest = v;
    err  = (rest <= 0 || rest >= NumeralBound);
    if (err) begin
      for (int i = 0; i < 5; i++) begin
        chars[n] = ErrorText[i];
        n++;
      end
    end else begin
      for (int d = 0; d < 13; d++) begin
        while (rest >= NumeralWeight[d]) begin
          chars[n] = NumeralHead[d];
          n++;
          if (NumeralTail[d] != NoChar) begin
            chars[n] = NumeralTail[d];
            n++;
          end
          rest -= NumeralWeight[d];
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      g.symbol   = chars[i];
      g.is_error = err;
      g.last     = (i == n - 1);
      pending_glyphs.push_back(g);
    end
  endfunction

  // Offer one value, idling beforehand at the given rate, and record its
  // characters once the transaction is taken.
  task automatic convert_value(input logic signed [InW-1:0] v, input int idle_pct);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(99) < idle_pct) begin
        start   <= 1'b0;
        value_i <= InW'($urandom);
      end else begin
        start   <= 1'b1;
        value_i <= v;
        break;
      end
    end
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    spell_numeral(v);
  endtask

  // Compare each strobed character against the oldest outstanding one.
  always @(posedge clk_i) begin
    glyph_t want;
    if (rst_ni && strobe_o) begin
      if (pending_glyphs.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected character: symbol %h is_error %b last %b",
                   symbol_o, is_error_o, last_o);
      end else begin
        want = pending_glyphs.pop_front();
        if (symbol_o !== want.symbol || is_error_o !== want.is_error ||
            last_o !== want.last) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("mismatch: expected symbol %h is_error %b last %b, got %h %b %b",
                     want.symbol, want.is_error, want.last,
                     symbol_o, is_error_o, last_o);
        end
      end
    end
  end

  // Both ends of the valid range, just outside it, the field extremes and two alternating bit patterns.
  task automatic test_range_limits();
    logic signed [InW-1:0] limits [9];
    limits = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sd3999, 16'sd4000,
               16'sh7FFF, 16'sh5555, -16'sd21846};
    foreach (limits[i]) convert_value(limits[i], 0);
  endtask

  // Every table weight on its own, so each symbol and pair appears alone.
  task automatic test_each_weight();
    foreach (NumeralWeight[d]) convert_value(InW'(NumeralWeight[d]), 0);
  endtask

  // The longest numeral and a mix of pairs and repeats.
  task automatic test_long_numerals();
    convert_value(16'sd3888, 0);
    convert_value(16'sd1994, 0);
    convert_value(16'sd2449, 0);
  endtask

  // Mostly in-range values, some raw 16-bit noise and some boundary values.
  task automatic test_random_values(input int count, input int idle_pct);
    int pick;
    logic signed [InW-1:0] v;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 80)
        v = InW'($urandom_range(3999, 1));
      else if (pick < 92)
        v = InW'($urandom);
      else if (pick < 96)
        v = InW'($urandom_range(2, 0)) - 16'sd1;
      else
        v = InW'($urandom_range(4001, 3998));
      convert_value(v, idle_pct);
    end
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    value_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_range_limits();
    test_each_weight();
    test_long_numerals();
    test_random_values(56, 0);
    test_random_values(56, 69);
    test_random_values(56, 0);
    test_random_values(56, 38);

    @(negedge clk_i);
    start <= 1'b0;

    // Let the last run finish, then wait out the drain period.
    while (pending_glyphs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0 && pending_glyphs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
